@@ rtl/core/delta_group_varint_encoder_macros.svh @@
// assertion macros used by the encoder back end (dgve_back)
`ifndef DELTA_GROUP_VARINT_ENCODER_MACROS_SVH
`define DELTA_GROUP_VARINT_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define DGVE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DGVE_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define DGVE_ASSERT(label, prop, msg)
`define DGVE_ASSERT_IMPL(label, pre, post, msg)
`endif

`endif

@@ rtl/core/dgve_pkg.sv @@
package dgve_pkg;

  typedef struct packed {
    logic [31:0] value;
    logic        first;
    logic        last;
    logic [16:0] block_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_end;
  } out_item_t;

  // one request from the front to the back: header, group, trailing zero group
  typedef struct packed {
    logic             hdr;
    logic             grp;
    logic             zgrp;
    logic             last;
    logic [16:0]      count;
    logic [3:0][1:0]  lens;
    logic [3:0][31:0] deltas;
  } job_t;

  // (bytes - 1) of the shortest little-endian form
  function automatic logic [1:0] len_code(input logic [31:0] d);
    logic [1:0] code;
    priority if (|d[31:24]) code = 2'd3;
    else if (|d[23:16]) code = 2'd2;
    else if (|d[15:8]) code = 2'd1;
    else code = 2'd0;
    return code;
  endfunction

endpackage

@@ rtl/core/dgve_queue.sv @@
module dgve_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  dgve_pkg::job_t wr_data_i,
  output logic           full_o,
  output logic           rd_valid_o,
  output dgve_pkg::job_t rd_data_o,
  input  logic           rd_pop_i
);
  import dgve_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o     = (cnt_q == CntFull);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/core/dgve_front.sv @@
module dgve_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  dgve_pkg::in_item_t in_item_i,
  output logic               job_valid_o,
  output dgve_pkg::job_t     job_o
);
  import dgve_pkg::*;

  logic [31:0]      prev_q;
  logic [2:0][31:0] gd_q;
  logic [2:0]       slot_q, slot_d;
  logic [2:0]       s, s1;
  logic [1:0]       lo;
  logic [31:0]      delta;
  logic             grp;

  always_comb begin
    s     = in_item_i.first ? 3'd0 : slot_q;
    delta = in_item_i.first ? in_item_i.value : in_item_i.value - prev_q;
    lo    = s[1:0];
    s1    = s + 3'd1;
    grp   = (s1[1:0] == 2'd0) || in_item_i.last;
    // padding into slots 4 to 7 needs a group of zero deltas on its own
    job_o.zgrp  = in_item_i.last && !s[2];
    job_o.hdr   = in_item_i.first;
    job_o.grp   = grp;
    job_o.last  = in_item_i.last;
    job_o.count = in_item_i.block_count;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < lo) begin
        job_o.deltas[i] = gd_q[i];
      end else if (2'(i) == lo) begin
        job_o.deltas[i] = delta;
      end else begin
        job_o.deltas[i] = '0;
      end
    end
    job_o.deltas[3] = (lo == 2'd3) ? delta : '0;
    for (int i = 0; i < 4; i++) begin
      job_o.lens[i] = len_code(job_o.deltas[i]);
    end
    slot_d      = in_item_i.last ? 3'd0 : s1;
    job_valid_o = in_valid_i && (in_item_i.first || grp);
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        if (lo == 2'(i)) begin
          gd_q[i] <= delta;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      slot_q <= '0;
    end else if (in_valid_i) begin
      prev_q <= in_item_i.value;
      slot_q <= slot_d;
    end
  end

endmodule

@@ rtl/core/dgve_back.sv @@
module dgve_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  dgve_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                empty,
  input  logic                pop,
  output dgve_pkg::out_item_t out_item_o
);
  import dgve_pkg::*;

  `include "delta_group_varint_encoder_macros.svh"

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_DESC  = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_ZERO  = 3'd4;
  localparam logic [2:0] ZeroLast = 3'd4;

  logic [2:0]  ph_q, ph_d, ph;
  logic [1:0]  cnt_q, cnt_d, slot_q, slot_d;
  logic [2:0]  zcnt_q, zcnt_d;
  logic [7:0]  byte_d;
  logic [31:0] hdr_word;
  logic        end_job, advance, out_valid_q;
  out_item_t   out_q;

  always_comb begin
    ph       = (ph_q == PH_START) ? (job_i.hdr ? PH_HDR : PH_DESC) : ph_q;
    hdr_word = {15'd0, job_i.count};
    ph_d     = ph;
    cnt_d    = cnt_q;
    slot_d   = slot_q;
    zcnt_d   = zcnt_q;
    byte_d   = '0;
    end_job  = 1'b0;
    unique case (ph)
      PH_HDR: begin
        byte_d = 8'(hdr_word >> {cnt_q, 3'b000});
        if (cnt_q == 2'd3) begin
          cnt_d = '0;
          if (job_i.grp) ph_d = PH_DESC;
          else end_job = 1'b1;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      PH_DESC: begin
        byte_d = job_i.lens;
        ph_d   = PH_DATA;
        slot_d = '0;
        cnt_d  = '0;
      end
      PH_DATA: begin
        byte_d = 8'(job_i.deltas[slot_q] >> {cnt_q, 3'b000});
        if (cnt_q == job_i.lens[slot_q]) begin
          cnt_d = '0;
          if (slot_q == 2'd3) begin
            if (job_i.zgrp) begin
              ph_d   = PH_ZERO;
              zcnt_d = '0;
            end else begin
              end_job = 1'b1;
            end
          end else begin
            slot_d = slot_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      PH_ZERO: begin
        // descriptor and four data bytes, all zero
        if (zcnt_q == ZeroLast) end_job = 1'b1;
        else zcnt_d = zcnt_q + 3'd1;
      end
      default: ph_d = PH_START;
    endcase
    if (end_job) begin
      ph_d   = PH_START;
      cnt_d  = '0;
      slot_d = '0;
      zcnt_d = '0;
    end
  end

  assign advance    = job_valid_i && (!out_valid_q || pop);
  assign job_pop_o  = advance && end_job;
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_byte  <= byte_d;
      out_q.run_last  <= end_job;
      out_q.block_end <= end_job && job_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_START;
      cnt_q       <= '0;
      slot_q      <= '0;
      zcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        ph_q        <= ph_d;
        cnt_q       <= cnt_d;
        slot_q      <= slot_d;
        zcnt_q      <= zcnt_d;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `DGVE_ASSERT_IMPL(a_mid_job_has_head, ph_q != PH_START, job_valid_i, "job left mid-way")
  `DGVE_ASSERT_IMPL(a_data_cnt_in_len, ph_q == PH_DATA, cnt_q <= job_i.lens[slot_q],
                    "data byte index past delta length")
  `DGVE_ASSERT_IMPL(a_zero_cnt_bound, ph_q == PH_ZERO, zcnt_q <= ZeroLast,
                    "zero group overran")
  `DGVE_ASSERT_IMPL(a_pop_needs_head, job_pop_o, job_valid_i, "job pop without head")
  `DGVE_ASSERT(a_run_last_pops, (advance && end_job) |=> (ph_q == PH_START && out_q.run_last),
               "run_last not tied to job end")

endmodule

@@ rtl/core/delta_group_varint_encoder.sv @@
// delta group varint encoder
// input queue side: drive in_item_i and push while full is low; one value per
// accepted push. first starts a block (4-byte little-endian count header, raw
// value), last closes it with zero deltas up to a multiple of eight.
// result queue side: while empty is low out_item_o holds the next byte of the
// stream; pop takes it. run_last marks the final byte of one input item,
// block_end the final byte of a block. items that complete no group and carry
// neither first nor last produce no bytes.
// the job of an item enters the job queue at the edge that takes its push; its
// first byte reaches the result ports through the output register when the
// job queue and output register are idle. throughput: one byte per cycle while
// jobs are queued and pop is not stalled, set by the byte serializer; an item
// emits 0 to 22 bytes. pushes are taken every cycle while the job queue has
// room (QUEUE_DEPTH jobs), so short items overlap the serializing of long ones.
// a stall on pop holds the current byte; the serializer and then the job queue
// fill up and full rises.
// reset clears the previous value, slot position, queue and output register;
// no clearing pass is needed.
module delta_group_varint_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  dgve_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output dgve_pkg::out_item_t out_item_o
);
  import dgve_pkg::*;

  logic  accept, fr_valid, hd_valid, hd_pop;
  job_t  fr_job, hd_job;

  assign accept = push && !full;

  dgve_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_item_i   (in_item_i),
    .job_valid_o (fr_valid),
    .job_o       (fr_job)
  );

  dgve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_data_i  (fr_job),
    .full_o     (full),
    .rd_valid_o (hd_valid),
    .rd_data_o  (hd_job),
    .rd_pop_i   (hd_pop)
  );

  dgve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (hd_valid),
    .job_i       (hd_job),
    .job_pop_o   (hd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

@@ sim/delta_group_varint_encoder_tb.sv @@
module delta_group_varint_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dgve_pkg::*;

  class stream_scoreboard;
    logic [31:0] prev_value;
    logic [31:0] group_delta[4];
    logic [2:0]  slot;
    logic [7:0]  run_bytes[$];
    out_item_t   expected_bytes[$];
    int          errors;

    function new();
      prev_value = '0;
      slot = '0;
      errors = 0;
      foreach (group_delta[i]) group_delta[i] = '0;
    endfunction

    function int byte_count(logic [31:0] d);
      if (d >= 32'(256 * 256 * 256)) return 4;
      if (d >= 32'(256 * 256)) return 3;
      if (d >= 32'd256) return 2;
      return 1;
    endfunction

    // store one delta, flush descriptor and payload once four are gathered
    function void add_delta(logic [31:0] d);
      logic [7:0] desc;
      int n;
      group_delta[slot[1:0]] = d;
      slot = slot + 3'd1;
      if (slot[1:0] == 2'd0) begin
        desc = '0;
        for (int i = 0; i < 4; i++) desc[2*i +: 2] = 2'(byte_count(group_delta[i]) - 1);
        run_bytes.push_back(desc);
        for (int i = 0; i < 4; i++) begin
          n = byte_count(group_delta[i]);
          for (int k = 0; k < n; k++) run_bytes.push_back(group_delta[i][8*k +: 8]);
        end
      end
    endfunction

    function void note_request(in_item_t req);
      logic [31:0] cnt;
      logic [31:0] d;
      out_item_t   o;
      run_bytes.delete();
      if (req.first) begin
        cnt = 32'(req.block_count);
        for (int k = 0; k < 4; k++) run_bytes.push_back(cnt[8*k +: 8]);
        slot = '0;
        d = req.value;
      end else begin
        d = req.value - prev_value;
      end
      prev_value = req.value;
      add_delta(d);
      if (req.last) begin
        while (slot != 3'd0) add_delta('0);
      end
      foreach (run_bytes[i]) begin
        o.out_byte = run_bytes[i];
        o.run_last = (i == run_bytes.size() - 1);
        o.block_end = o.run_last && req.last;
        expected_bytes.push_back(o);
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected byte %h run_last %b block_end %b", $realtime,
                   got.out_byte, got.run_last, got.block_end);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
          got.block_end !== want.block_end) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp byte %h run_last %b block_end %b, got %h %b %b",
                   $realtime, want.out_byte, want.run_last, want.block_end,
                   got.out_byte, got.run_last, got.block_end);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  stream_scoreboard sb = new();
  bit quiet = 1'b0;
  int sent = 0;

  delta_group_varint_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic sender_gap();
    int n;
    if (quiet || $urandom_range(0, 4) != 0) return;
    n = $urandom_range(1, 13);
    @(negedge clk_i);
    push <= 1'b0;
    in_item_i <= in_item_t'(51'({$urandom, $urandom}));
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_value(logic [31:0] value, bit first, bit last, logic [16:0] count);
    in_item_t req;
    req.value = value;
    req.first = first;
    req.last = last;
    req.block_count = count;
    @(negedge clk_i);
    push <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (full);
    sb.note_request(req);
    sent++;
    sender_gap();
  endtask

  // hold off new requests until the encoder has handed out every byte
  task automatic drain_all();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] next_step();
    case ($urandom_range(0, 5))
      0, 1:    return 32'($urandom_range(0, 255));
      2:       return 32'($urandom_range(256, 65535));
      3:       return 32'($urandom_range(65536, 16777215));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block();
    int          len;
    bit          noisy;
    logic [16:0] count;
    logic [31:0] v;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    noisy = ($urandom_range(0, 6) == 0);
    count = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'(len);
    v = $urandom;
    for (int i = 0; i < len; i++) begin
      if (noisy)
        send_value($urandom, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                   17'($urandom));
      else
        send_value(v, i == 0, i == len - 1, count);
      v = v + next_step();
    end
  endtask

  task automatic directed();
    // no block start after reset: deltas against zero, all four widths
    send_value(32'd5, 1'b0, 1'b0, 17'd0);
    send_value(32'd300, 1'b0, 1'b0, 17'd0);
    send_value(32'h0001_012C, 1'b0, 1'b0, 17'd0);
    send_value(32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0);
    send_value(32'h0000_0000, 1'b0, 1'b1, 17'd0);
    // first and last on one request, widest count
    send_value(32'hFFFF_FFFF, 1'b1, 1'b1, 17'h1FFFF);
    // continuing after the block has ended
    send_value(32'hFFFF_FFFF, 1'b0, 1'b0, 17'h15555);
    // a restart with zero count in the middle of a group
    send_value(32'h0100_0000, 1'b1, 1'b0, 17'd0);
    send_value(32'h0100_0100, 1'b0, 1'b0, 17'd0);
    // exactly eight deltas, nothing to pad
    send_value(32'h0000_0007, 1'b1, 1'b0, 17'd65536);
    send_value(32'h0000_0009, 1'b0, 1'b0, 17'd0);
    send_value(32'h0000_0109, 1'b0, 1'b0, 17'd0);
    send_value(32'h0001_0109, 1'b0, 1'b0, 17'd0);
    send_value(32'h0101_0109, 1'b0, 1'b0, 17'd0);
    send_value(32'h0201_0109, 1'b0, 1'b0, 17'd0);
    send_value(32'h0201_0208, 1'b0, 1'b0, 17'd0);
    send_value(32'h0202_0208, 1'b0, 1'b1, 17'd0);
    send_value(32'h0000_0000, 1'b1, 1'b0, 17'h0AAAA);
    send_value(32'h8000_0000, 1'b0, 1'b0, 17'h15555);
    send_value(32'h7FFF_FFFF, 1'b0, 1'b1, 17'd1);
    send_value(32'h5555_AAAA, 1'b1, 1'b0, 17'd8);
    send_value(32'hAAAA_5555, 1'b0, 1'b1, 17'd0);
  endtask

  // result side: pop with random stall bursts
  initial begin
    int stall;
    stall = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_byte(out_item_o);
  end

  initial begin
    bit paused;
    paused = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    in_item_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    directed();
    drain_all();
    while (sent < 370) begin
      if (sent >= 320) quiet = 1'b1;
      if (!paused && sent >= 200) begin
        drain_all();
        paused = 1'b1;
      end
      send_block();
    end
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/dgve_pkg.sv
rtl/core/dgve_queue.sv
rtl/core/dgve_front.sv
rtl/core/dgve_back.sv
rtl/core/delta_group_varint_encoder.sv
sim/delta_group_varint_encoder_tb.sv
